/* rtl/tbt_pkg.sv */
`default_nettype none

package tbt_pkg;

   // Geometry of the tracker.
   localparam int NUM_CHANNELS = 4;
   localparam int CHAN_W       = 2;
   localparam int READING_W    = 16;
   localparam int CFG_W        = 16;
   localparam int FRAC_W       = 8;
   localparam int AVG_W        = READING_W + FRAC_W;
   localparam int STATE_W      = 3;
   localparam int CSR_IDX_W    = 3;
   localparam int ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Divider operands: a 16 x 24 product plus the scaled reading, over a 17-bit count.
   localparam int PROD_W = CFG_W + AVG_W;
   localparam int NUM_W  = PROD_W + 1;
   localparam int DEN_W  = CFG_W + 1;

   typedef enum logic [STATE_W-1:0] {
      MODE_CAL = 3'd0,
      MODE_REL = 3'd1,
      MODE_R2P = 3'd2,
      MODE_PRS = 3'd3,
      MODE_P2R = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_SAMPLES = 3'd0,
      CSR_FILTER_LEN  = 3'd1,
      CSR_PRESS_THR   = 3'd2,
      CSR_RELEASE_THR = 3'd3,
      CSR_PRESS_DEB   = 3'd4,
      CSR_RELEASE_DEB = 3'd5,
      CSR_HOLD_LIMIT  = 3'd6
   } csr_idx_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_EVAL,
      SEQ_MUL,
      SEQ_START,
      SEQ_DIV,
      SEQ_DONE
   } seq_type;

   // One memory word per channel.
   typedef struct packed {
      logic [STATE_W-1:0] mode;
      logic [CFG_W-1:0]   cnt;
      logic [CFG_W-1:0]   hold;
      logic [AVG_W-1:0]   avg;
   } chan_state_type;

   localparam int ENTRY_W = $bits(chan_state_type);

   typedef struct packed {
      logic [CFG_W-1:0] cal_samples;
      logic [CFG_W-1:0] filter_len;
      logic [CFG_W-1:0] press_thr;
      logic [CFG_W-1:0] release_thr;
      logic [CFG_W-1:0] press_deb;
      logic [CFG_W-1:0] release_deb;
      logic [CFG_W-1:0] hold_limit;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [AVG_W-1:0] quot;
   } div_rsp_type;

endpackage

`default_nettype wire

/* rtl/tbt_req_if.sv */
`default_nettype none

interface tbt_req_if import tbt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHAN_W-1:0]    channel;
   logic [READING_W-1:0] reading;

   modport source (output valid, channel, reading, input ready);
   modport sink   (input valid, channel, reading, output ready);
endinterface

`default_nettype wire

/* rtl/tbt_rsp_if.sv */
`default_nettype none

interface tbt_rsp_if import tbt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHAN_W-1:0]    out_channel;
   logic [STATE_W-1:0]   touch_state;
   logic                 touched;
   logic [READING_W-1:0] baseline;

   modport source (output valid, out_channel, touch_state, touched, baseline, input ready);
   modport sink   (input valid, out_channel, touch_state, touched, baseline, output ready);
endinterface

`default_nettype wire

/* rtl/tbt_csr_if.sv */
`default_nettype none

interface tbt_csr_if import tbt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/tbt_ram.sv */
`default_nettype none

module tbt_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/tbt_csr.sv */
`default_nettype none

module tbt_csr import tbt_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   tbt_csr_if.sink    csr,
   output cfg_type    cfg
);

   localparam cfg_type CFG_RESET = '{
      cal_samples: 16'd64,
      filter_len:  16'd16,
      press_thr:   16'd100,
      release_thr: 16'd80,
      press_deb:   16'd3,
      release_deb: 16'd3,
      hold_limit:  16'd1000
   };

   cfg_type cfg_ff, cfg_in;

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr_idx_type'(csr.index))
            CSR_CAL_SAMPLES: cfg_in.cal_samples = csr.data;
            CSR_FILTER_LEN:  cfg_in.filter_len  = csr.data;
            CSR_PRESS_THR:   cfg_in.press_thr   = csr.data;
            CSR_RELEASE_THR: cfg_in.release_thr = csr.data;
            CSR_PRESS_DEB:   cfg_in.press_deb   = csr.data;
            CSR_RELEASE_DEB: cfg_in.release_deb = csr.data;
            CSR_HOLD_LIMIT:  cfg_in.hold_limit  = csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/tbt_div.sv */
`default_nettype none

module tbt_div import tbt_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   // Restoring division, one quotient bit per cycle. The caller guarantees that
   // the quotient fits in AVG_W bits, so the upper dividend bits start below den.
   localparam int CNT_W = $clog2(AVG_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [AVG_W-1:0] shf_ff, shf_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             qbit;

   always_comb begin
      trial   = {rem_ff, shf_ff[AVG_W-1]};
      diff    = trial - {1'b0, den_ff};
      qbit    = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.num[NUM_W-1:AVG_W];
         shf_in  = req.num[AVG_W-1:0];
         den_in  = req.den;
         cnt_in  = CNT_W'(AVG_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         shf_in = {shf_ff[AVG_W-2:0], qbit};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = shf_ff;

endmodule

`default_nettype wire

/* rtl/touch_button_baseline_tracker.sv */
`default_nettype none

// Channel    Direction  Payload                                        Handshake
// req_if     in         channel, reading                               valid/ready
// rsp_if     out        out_channel, touch_state, touched, baseline    valid/ready
// csr_if     in         index, data (register write)                   valid/ready
//
// One request is processed at a time. A request that keeps the baseline goes from the state
// read straight to the result; one that averages (calibrating, or released and not low) also
// passes through the multiply and the 24-step divider. The state memory is read in the cycle
// after acceptance and written back when the result is loaded. Synchronous reset clears the
// per-channel valid bits, so every channel restarts calibration at once. A waiting result
// holds the sequencer at its final step; no new request is accepted meanwhile.

module touch_button_baseline_tracker import tbt_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   tbt_req_if.sink   req_if,
   tbt_rsp_if.source rsp_if,
   tbt_csr_if.sink   csr_if
);

   // A reading is low when reading + threshold lies below the baseline, compared
   // exactly in 16.8 fixed point.
   function automatic logic is_low(input logic [READING_W-1:0] rd,
                                   input logic [CFG_W-1:0]     thr,
                                   input logic [AVG_W-1:0]     avg);
      logic [CFG_W:0] sum;
      sum = {1'b0, rd} + {1'b0, thr};
      return {sum, {FRAC_W{1'b0}}} < {1'b0, avg};
   endfunction

   cfg_type cfg;

   tbt_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_if),
      .cfg   (cfg)
   );

   // Sequencer and request registers.
   seq_type              seq_ff, seq_in;
   logic [CHAN_W-1:0]    ch_ff, ch_in;
   logic [READING_W-1:0] rd_ff, rd_in;
   chan_state_type       upd_ff, upd_in;
   logic [CFG_W-1:0]     mul_a_ff, mul_a_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 need_div;
   logic [NUM_CHANNELS-1:0] valid_ff, valid_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]    rsp_ch_ff;
   logic [STATE_W-1:0]   rsp_state_ff;
   logic                 rsp_touched_ff;
   logic [READING_W-1:0] rsp_base_ff;

   logic                 accept;
   logic                 in_range;
   logic                 out_free;
   logic                 ram_re;
   logic                 ram_we;
   logic                 load_out;
   logic [ENTRY_W-1:0]   ram_q;
   logic [ADDR_W-1:0]    addr;
   chan_state_type       cur;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   assign addr     = ADDR_W'(ch_ff);
   assign in_range = (int'(req_if.channel) < NUM_CHANNELS);
   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   tbt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_CHANNELS)
   ) u_state_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr),
      .wdata (upd_ff),
      .re    (ram_re),
      .raddr (addr),
      .rdata (ram_q)
   );

   tbt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Next state of the sequencer.
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_IDLE:  if (accept && in_range) seq_in = SEQ_READ;
         SEQ_READ:  seq_in = SEQ_EVAL;
         SEQ_EVAL:  seq_in = need_div ? SEQ_MUL : SEQ_DONE;
         SEQ_MUL:   seq_in = SEQ_START;
         SEQ_START: seq_in = SEQ_DIV;
         SEQ_DIV:   if (div_rsp.done) seq_in = SEQ_DONE;
         SEQ_DONE:  if (out_free) seq_in = SEQ_IDLE;
         default:   seq_in = SEQ_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_if.ready  = 1'b0;
      ram_re        = 1'b0;
      ram_we        = 1'b0;
      load_out      = 1'b0;
      div_req.start = 1'b0;
      // The divider sees the weighted sum of old baseline and reading, over the weight.
      div_req.num   = NUM_W'(prod_ff) + NUM_W'({rd_ff, {FRAC_W{1'b0}}});
      div_req.den   = den_ff;
      case (seq_ff)
         SEQ_IDLE:  req_if.ready = 1'b1;
         SEQ_READ:  ram_re = 1'b1;
         SEQ_START: div_req.start = 1'b1;
         SEQ_DONE: begin
            ram_we   = out_free;
            load_out = out_free;
         end
         default: ;
      endcase
   end

   // A channel that was never written since reset reads as calibrating with zeros.
   assign cur = valid_ff[addr] ? chan_state_type'(ram_q) : '0;

   // Per-channel state machine, evaluated in the cycle after the memory read.
   always_comb begin
      logic [CFG_W:0]   cnt_p1;
      logic [CFG_W:0]   hold_p1;
      logic [CFG_W-1:0] hold_sat;
      logic [CFG_W-1:0] flen;
      logic             low_press;
      logic             low_release;

      cnt_p1      = {1'b0, cur.cnt} + (CFG_W+1)'(1);
      hold_p1     = {1'b0, cur.hold} + (CFG_W+1)'(1);
      hold_sat    = (cur.hold == {CFG_W{1'b1}}) ? cur.hold : hold_p1[CFG_W-1:0];
      flen        = (cfg.filter_len == '0) ? CFG_W'(1) : cfg.filter_len;
      low_press   = is_low(rd_ff, cfg.press_thr, cur.avg);
      low_release = is_low(rd_ff, cfg.release_thr, cur.avg);

      upd_in   = cur;
      mul_a_in = cur.cnt;
      den_in   = cnt_p1;
      need_div = 1'b0;

      case (cur.mode)
         MODE_CAL: begin
            // Running mean: the divider replaces the baseline later.
            if (cur.cnt < cfg.cal_samples) begin
               need_div   = 1'b1;
               upd_in.cnt = cnt_p1[CFG_W-1:0];
               upd_in.mode = (cnt_p1 >= {1'b0, cfg.cal_samples}) ? MODE_REL : MODE_CAL;
            end else begin
               upd_in.mode = MODE_REL;
            end
         end
         MODE_REL: begin
            if (low_press) begin
               upd_in.cnt  = CFG_W'(1);
               upd_in.mode = MODE_R2P;
            end else begin
               // IIR average of length flen.
               need_div = 1'b1;
               mul_a_in = flen - CFG_W'(1);
               den_in   = {1'b0, flen};
            end
         end
         MODE_R2P: begin
            if (!low_press) begin
               upd_in.cnt  = CFG_W'(1);
               upd_in.hold = CFG_W'(1);
               upd_in.mode = MODE_REL;
            end else if (cnt_p1 < {1'b0, cfg.press_deb}) begin
               upd_in.cnt = cnt_p1[CFG_W-1:0];
            end else begin
               upd_in.cnt  = CFG_W'(1);
               upd_in.mode = MODE_PRS;
            end
         end
         MODE_PRS: begin
            if (low_release) begin
               if (hold_p1 > {1'b0, cfg.hold_limit}) begin
                  // Held too long: start calibration over.
                  upd_in = '0;
               end else begin
                  upd_in.hold = hold_sat;
               end
            end else begin
               upd_in.cnt  = CFG_W'(1);
               upd_in.mode = MODE_P2R;
            end
         end
         MODE_P2R: begin
            if (low_release) begin
               upd_in.mode = MODE_PRS;
               upd_in.hold = hold_sat;
            end else if (cnt_p1 < {1'b0, cfg.release_deb}) begin
               upd_in.cnt = cnt_p1[CFG_W-1:0];
            end else begin
               upd_in.cnt  = CFG_W'(1);
               upd_in.mode = MODE_REL;
            end
         end
         default: begin
            // An unknown mode restarts calibration.
            upd_in = '0;
         end
      endcase
   end

   assign prod_in = mul_a_ff * upd_ff.avg;

   assign ch_in = accept ? req_if.channel : ch_ff;
   assign rd_in = accept ? req_if.reading : rd_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ram_we) begin
         valid_in[addr] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
      rd_ff <= rd_in;
      if (seq_ff == SEQ_EVAL) begin
         upd_ff   <= upd_in;
         mul_a_ff <= mul_a_in;
         den_ff   <= den_in;
      end else if (seq_ff == SEQ_DIV && div_rsp.done) begin
         upd_ff.avg <= div_rsp.quot;
      end
      if (seq_ff == SEQ_MUL) begin
         prod_ff <= prod_in;
      end
      if (load_out) begin
         rsp_ch_ff      <= ch_ff;
         rsp_state_ff   <= upd_ff.mode;
         rsp_touched_ff <= (upd_ff.mode == MODE_PRS) || (upd_ff.mode == MODE_P2R);
         rsp_base_ff    <= upd_ff.avg[AVG_W-1:FRAC_W];
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.out_channel = rsp_ch_ff;
   assign rsp_if.touch_state = rsp_state_ff;
   assign rsp_if.touched     = rsp_touched_ff;
   assign rsp_if.baseline    = rsp_base_ff;

endmodule

`default_nettype wire

/* tb/sv/tb_touch_button_baseline_tracker.sv */
`timescale 1ns / 1ps

module tb_touch_button_baseline_tracker;
   import tbt_pkg::*;

   // The receiver stops taking reports for this many cycles when asked, so that
   // the tracker fills up and pushes back on the request side.
   localparam int unsigned RSP_HOLD_OFF    = 300;
   localparam int unsigned HOLD_MAX        = 65535;
   localparam int unsigned HOLD_TEST_LIMIT = 24;

   // One expected report, in the same shape as the result channel.
   typedef struct {
      logic [CHAN_W-1:0]    channel;
      mode_type             state;
      logic                 touched;
      logic [READING_W-1:0] baseline;
   } touch_report_type;

   logic clock = 1'b0;
   logic reset;

   tbt_req_if req_if ();
   tbt_rsp_if rsp_if ();
   tbt_csr_if csr_if ();

   touch_button_baseline_tracker i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Our own copy of the tracker: the register settings and the per-channel
   // state machine, baseline and counters, advanced once per accepted request.
   cfg_type              tracker_cfg;
   mode_type             chan_mode [NUM_CHANNELS];
   logic [CFG_W-1:0]     chan_cnt  [NUM_CHANNELS];
   logic [CFG_W-1:0]     chan_hold [NUM_CHANNELS];
   logic [AVG_W-1:0]     chan_avg  [NUM_CHANNELS];

   // Reports that the tracker still owes us, oldest first.
   touch_report_type expected_reports [$];
   int               mismatch_count = 0;

   // Traffic shaping. The steady flags turn off random idling on one side; the
   // hold-off counter is bumped by the stimulus and served by the receiver.
   bit            sender_steady     = 1'b0;
   bit            receiver_steady   = 1'b0;
   int unsigned   hold_off_requests = 0;

   // Per-channel model of the sensor used by the random traffic: a resting level
   // and whether a finger is currently on the button.
   int            idle_level  [NUM_CHANNELS];
   bit            finger_down [NUM_CHANNELS];

   function automatic cfg_type make_settings(input int unsigned cal, input int unsigned filt,
                                             input int unsigned pthr, input int unsigned rthr,
                                             input int unsigned pdeb, input int unsigned rdeb,
                                             input int unsigned hold);
      cfg_type s;
      s.cal_samples = cal[CFG_W-1:0];
      s.filter_len  = filt[CFG_W-1:0];
      s.press_thr   = pthr[CFG_W-1:0];
      s.release_thr = rthr[CFG_W-1:0];
      s.press_deb   = pdeb[CFG_W-1:0];
      s.release_deb = rdeb[CFG_W-1:0];
      s.hold_limit  = hold[CFG_W-1:0];
      return s;
   endfunction

   // A reading counts as low when it plus the threshold lies strictly below the
   // baseline. Everything is compared in 16.8 with room to spare, so no wrap.
   function automatic bit below_baseline(input longint unsigned scaled_reading,
                                         input logic [CFG_W-1:0] thr,
                                         input longint unsigned avg);
      longint unsigned scaled_thr;
      scaled_thr = thr;
      return (scaled_reading + (scaled_thr << FRAC_W)) < avg;
   endfunction

   // Advances one channel by one reading and returns the report it must produce.
   function automatic touch_report_type track_reading(input logic [CHAN_W-1:0] ch,
                                                      input logic [READING_W-1:0] rd);
      mode_type         mode;
      longint unsigned  cnt, hold, avg, scaled, taps;
      touch_report_type report;

      mode   = chan_mode[ch];
      cnt    = chan_cnt[ch];
      hold   = chan_hold[ch];
      avg    = chan_avg[ch];
      scaled = rd;
      scaled = scaled << FRAC_W;

      case (mode)
         MODE_CAL: begin
            // Running mean; a count already at or past the target skips the update.
            if (cnt < tracker_cfg.cal_samples) begin
               avg = (cnt * avg + scaled) / (cnt + 1);
               cnt = cnt + 1;
            end
            if (cnt >= tracker_cfg.cal_samples) begin
               mode = MODE_REL;
            end
         end
         MODE_REL: begin
            if (below_baseline(scaled, tracker_cfg.press_thr, avg)) begin
               cnt  = 1;
               mode = MODE_R2P;
            end else begin
               // A filter length of zero behaves as one: the baseline takes the reading.
               taps = (tracker_cfg.filter_len == 0) ? 1 : tracker_cfg.filter_len;
               avg  = ((taps - 1) * avg + scaled) / taps;
            end
         end
         MODE_R2P: begin
            if (!below_baseline(scaled, tracker_cfg.press_thr, avg)) begin
               // A press that does not hold falls back and restarts the hold count.
               cnt  = 1;
               hold = 1;
               mode = MODE_REL;
            end else if (cnt + 1 < tracker_cfg.press_deb) begin
               cnt = cnt + 1;
            end else begin
               cnt  = 1;
               mode = MODE_PRS;
            end
         end
         MODE_PRS: begin
            if (below_baseline(scaled, tracker_cfg.release_thr, avg)) begin
               if (hold + 1 > tracker_cfg.hold_limit) begin
                  cnt  = 0;
                  hold = 0;
                  avg  = 0;
                  mode = MODE_CAL;
               end else begin
                  hold = (hold >= HOLD_MAX) ? HOLD_MAX : hold + 1;
               end
            end else begin
               cnt  = 1;
               mode = MODE_P2R;
            end
         end
         MODE_P2R: begin
            if (below_baseline(scaled, tracker_cfg.release_thr, avg)) begin
               mode = MODE_PRS;
               hold = (hold >= HOLD_MAX) ? HOLD_MAX : hold + 1;
            end else if (cnt + 1 < tracker_cfg.release_deb) begin
               cnt = cnt + 1;
            end else begin
               cnt  = 1;
               mode = MODE_REL;
            end
         end
         default: begin
            cnt  = 0;
            hold = 0;
            avg  = 0;
            mode = MODE_CAL;
         end
      endcase

      chan_mode[ch] = mode;
      chan_cnt[ch]  = cnt[CFG_W-1:0];
      chan_hold[ch] = hold[CFG_W-1:0];
      chan_avg[ch]  = avg[AVG_W-1:0];

      report.channel  = ch;
      report.state    = mode;
      report.touched  = (mode == MODE_PRS) || (mode == MODE_P2R);
      report.baseline = chan_avg[ch][AVG_W-1:FRAC_W];
      return report;
   endfunction

   // Offers one request and waits for it to be taken. Valid is left high on
   // return, so back-to-back requests keep it asserted without a glitch; an idle
   // gap, when one is drawn, lowers it first.
   task automatic send_reading(input logic [CHAN_W-1:0] ch, input logic [READING_W-1:0] rd);
      int unsigned gap;
      if (!sender_steady && $urandom_range(99) < 19) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.channel <= ch;
      req_if.reading <= rd;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_reports.push_back(track_reading(ch, rd));
   endtask

   // Stops offering requests and waits until every owed report has come back.
   // Each request yields exactly one report, so an empty queue means the
   // tracker is idle and registers may be written.
   task automatic drain_reports();
      req_if.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   // Writes one register; valid stays high so the next write can follow at once.
   task automatic write_register(input csr_idx_type idx, input logic [CFG_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         CSR_CAL_SAMPLES: tracker_cfg.cal_samples = value;
         CSR_FILTER_LEN:  tracker_cfg.filter_len  = value;
         CSR_PRESS_THR:   tracker_cfg.press_thr   = value;
         CSR_RELEASE_THR: tracker_cfg.release_thr = value;
         CSR_PRESS_DEB:   tracker_cfg.press_deb   = value;
         CSR_RELEASE_DEB: tracker_cfg.release_deb = value;
         CSR_HOLD_LIMIT:  tracker_cfg.hold_limit  = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input cfg_type s);
      write_register(CSR_CAL_SAMPLES, s.cal_samples);
      write_register(CSR_FILTER_LEN,  s.filter_len);
      write_register(CSR_PRESS_THR,   s.press_thr);
      write_register(CSR_RELEASE_THR, s.release_thr);
      write_register(CSR_PRESS_DEB,   s.press_deb);
      write_register(CSR_RELEASE_DEB, s.release_deb);
      write_register(CSR_HOLD_LIMIT,  s.hold_limit);
      csr_if.valid <= 1'b0;
   endtask

   // A plausible sensor: mostly readings that rest near the channel's level or
   // dip under it while a finger is down, with some fully random noise mixed in.
   function automatic logic [READING_W-1:0] pick_reading(input logic [CHAN_W-1:0] ch);
      int level;
      int drop;
      if ($urandom_range(99) < 15) begin
         return READING_W'($urandom);
      end
      if ($urandom_range(99) < 8) begin
         finger_down[ch] = !finger_down[ch];
      end
      level = idle_level[ch];
      if (finger_down[ch]) begin
         drop  = int'(tracker_cfg.press_thr) +
                 int'($urandom_range(0, 2 * tracker_cfg.press_thr + 60));
         level = level - drop;
      end else begin
         level = level + int'($urandom_range(0, 40)) - 20;
      end
      if (level < 0) level = 0;
      if (level > 65535) level = 65535;
      return READING_W'(level);
   endfunction

   // One phase of random traffic under fixed settings. With squeeze set, the
   // receiver is told to hold off a third of the way in while the sender keeps
   // offering requests back to back.
   task automatic run_traffic(input cfg_type s, input int unsigned count, input bit squeeze);
      int unsigned       k;
      logic [CHAN_W-1:0] ch;
      apply_settings(s);
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         idle_level[c]  = $urandom_range(1000, 64000);
         finger_down[c] = 1'b0;
      end
      for (k = 0; k < count; k++) begin
         if (squeeze && k == count / 3) begin
            hold_off_requests++;
            sender_steady = 1'b1;
         end
         if (squeeze && k == count / 3 + 40) begin
            sender_steady = 1'b0;
         end
         ch = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
         send_reading(ch, pick_reading(ch));
      end
      drain_reports();
   endtask

   // With the reset settings untouched: the running mean during calibration,
   // fed with the extreme readings and an alternating bit pattern.
   task automatic test_calibration_mean();
      send_reading(2'd0, 16'hFFFF);
      send_reading(2'd0, 16'h0000);
      send_reading(2'd0, 16'h8001);
      send_reading(2'd0, 16'hFFFF);
      send_reading(2'd1, 16'h5A5A);
      drain_reports();
   endtask

   // Every register at zero. Channel 2 is still fresh, so it leaves calibration
   // at once without averaging, then walks the whole press and release cycle
   // where zero filter length and zero debounce act as one, and finally a zero
   // hold limit recalibrates on the first low reading while pressed.
   task automatic test_zero_settings();
      apply_settings(make_settings(0, 0, 0, 0, 0, 0, 0));
      send_reading(2'd2, 16'd500);    // leaves calibration, baseline still zero
      send_reading(2'd2, 16'd1000);   // baseline takes the reading
      send_reading(2'd2, 16'd10);     // low: start of a press
      send_reading(2'd2, 16'd1000);   // press not held, back to released
      send_reading(2'd2, 16'd10);
      send_reading(2'd2, 16'd10);     // press confirmed
      send_reading(2'd2, 16'd2000);   // release starts
      send_reading(2'd2, 16'd2000);   // release confirmed
      send_reading(2'd2, 16'd10);
      send_reading(2'd2, 16'd10);
      send_reading(2'd2, 16'd10);     // held too long: recalibrate
      send_reading(2'd2, 16'd0);
      drain_reports();
   endtask

   // Every register at its maximum: calibration runs long, the thresholds can
   // never be crossed and the longest filter barely moves the baseline.
   task automatic test_extreme_settings();
      apply_settings(make_settings(65535, 65535, 65535, 65535, 65535, 65535, 65535));
      send_reading(2'd3, 16'h0000);
      send_reading(2'd3, 16'h0000);
      send_reading(2'd3, 16'h0001);
      send_reading(2'd2, 16'hFFFF);
      drain_reports();
   endtask

   // Drives a press past the hold limit. Channel 3 settles at a baseline of
   // 40000, a failed press sets its hold count to one, and a confirmed press is
   // then held until the count reaches the limit. A short release and a new low
   // reading carry the count on past the limit, so the next low reading
   // recalibrates.
   task automatic test_hold_limit();
      apply_settings(make_settings(1, 1, 0, 0, 1, 2, HOLD_TEST_LIMIT));
      sender_steady = 1'b1;
      send_reading(2'd3, 16'd40000);
      send_reading(2'd3, 16'd40000);
      send_reading(2'd3, 16'd100);
      send_reading(2'd3, 16'd40000);
      send_reading(2'd3, 16'd100);
      send_reading(2'd3, 16'd100);
      repeat (HOLD_TEST_LIMIT - 1) send_reading(2'd3, READING_W'($urandom_range(0, 39000)));
      send_reading(2'd3, 16'd40000);
      send_reading(2'd3, 16'd100);
      send_reading(2'd3, 16'd100);
      sender_steady = 1'b0;
      drain_reports();
   endtask

   // Random phases: the reset settings, several small random settings where
   // presses, releases and recalibrations happen often, one phase under
   // back-pressure, one with no idling on either side, and all zeros.
   task automatic test_random_traffic();
      run_traffic(make_settings(64, 16, 100, 80, 3, 3, 1000), 300, 1'b0);
      run_traffic(make_settings($urandom_range(0, 8), $urandom_range(0, 32),
                                $urandom_range(0, 2000), $urandom_range(0, 2000),
                                $urandom_range(0, 5), $urandom_range(0, 5),
                                $urandom_range(0, 30)), 300, 1'b1);
      sender_steady   = 1'b1;
      receiver_steady = 1'b1;
      run_traffic(make_settings($urandom_range(1, 8), $urandom_range(1, 32),
                                $urandom_range(0, 2000), $urandom_range(0, 2000),
                                $urandom_range(1, 5), $urandom_range(1, 5),
                                $urandom_range(1, 30)), 250, 1'b0);
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      run_traffic(make_settings(0, 0, 0, 0, 0, 0, 0), 200, 1'b0);
      repeat (2) begin
         run_traffic(make_settings($urandom_range(0, 8), $urandom_range(0, 32),
                                   $urandom_range(0, 2000), $urandom_range(0, 2000),
                                   $urandom_range(0, 5), $urandom_range(0, 5),
                                   $urandom_range(0, 30)), 300, 1'b0);
      end
   endtask

   // Receiver: random back-pressure, plus long hold-offs on request.
   initial begin
      int unsigned hold_off_left;
      int unsigned hold_off_served;
      hold_off_left   = 0;
      hold_off_served = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_served != hold_off_requests) begin
            hold_off_served = hold_off_requests;
            hold_off_left   = RSP_HOLD_OFF;
         end
         if (hold_off_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_if.ready <= receiver_steady || ($urandom_range(99) >= 19);
         end
      end
   end

   // Every accepted report is checked field by field against the oldest
   // expectation. The values are those from before the edge, since both sides
   // update theirs with nonblocking assignments.
   always @(posedge clock) begin
      touch_report_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_reports.size() == 0) begin
            $error("report for channel %0d arrived with none outstanding",
                   rsp_if.out_channel);
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_if.out_channel !== want.channel) begin
               $error("out_channel: expected %0d, got %0d", want.channel, rsp_if.out_channel);
               mismatch_count++;
            end
            if (rsp_if.touch_state !== want.state) begin
               $error("touch_state: expected %0d, got %0d", want.state, rsp_if.touch_state);
               mismatch_count++;
            end
            if (rsp_if.touched !== want.touched) begin
               $error("touched: expected %0d, got %0d", want.touched, rsp_if.touched);
               mismatch_count++;
            end
            if (rsp_if.baseline !== want.baseline) begin
               $error("baseline: expected %0d, got %0d", want.baseline, rsp_if.baseline);
               mismatch_count++;
            end
         end
      end
   end

   // Main sequence: reset, then each test in turn, then the verdict.
   initial begin
      tracker_cfg = make_settings(64, 16, 100, 80, 3, 3, 1000);
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         chan_mode[c] = MODE_CAL;
         chan_cnt[c]  = '0;
         chan_hold[c] = '0;
         chan_avg[c]  = '0;
      end
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.channel <= '0;
      req_if.reading <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= CSR_CAL_SAMPLES;
      csr_if.data    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_calibration_mean();
      test_zero_settings();
      test_extreme_settings();
      test_hold_limit();
      test_random_traffic();

      // Everything is back; give the tracker a little longer in case it sends
      // a report nobody asked for.
      drain_reports();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run, with every request taking
   // the divider's full time behind the longest idle gaps and hold-offs.
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
